// ===== rtl/core/assert_macros.svh =====
// shared assertion wrappers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/lzw_pkg.sv =====
package lzw_pkg;

    localparam int DICT_ENTRIES_DEF = 4096;
    localparam int BUCKETS_DEF      = 4096;
    localparam int ROOT_COUNT       = 256;
    localparam int SYM_SHIFT        = 6;
    localparam int START_WIDTH      = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_ENT,
        S_PUSH,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic head_rd;
        logic ent_rd;
        logic wr;
    } t_dict_cmd;

endpackage

// ===== rtl/core/lzw_dict.sv =====
module lzw_dict #(
    parameter int CW = 13,
    parameter int IW = 12,
    parameter int BW = 12
) (
    input  logic                i_clk,
    input  lzw_pkg::t_dict_cmd  i_cmd,
    input  logic [BW-1:0]       i_head_addr,
    input  logic [IW-1:0]       i_ent_addr,
    input  logic [BW-1:0]       i_wr_bucket,
    input  logic [CW-1:0]       i_wr_code,
    input  logic [CW-1:0]       i_wr_prefix,
    input  logic [7:0]          i_wr_symbol,
    input  logic [CW-1:0]       i_wr_link,
    output logic [CW-1:0]       o_head,
    output logic [CW-1:0]       o_ent_prefix,
    output logic [7:0]          o_ent_symbol,
    output logic [CW-1:0]       o_ent_link
);

    localparam int EW = 2 * CW + 8;

    logic [CW-1:0] r_heads [2**BW];
    logic [EW-1:0] r_ents  [2**IW];
    logic [EW-1:0] r_ent_q;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_heads[i_wr_bucket] <= i_wr_code;
        end
        if (i_cmd.head_rd) begin
            o_head <= r_heads[i_head_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_ents[i_wr_code[IW-1:0]] <= {i_wr_prefix, i_wr_symbol, i_wr_link};
        end
        if (i_cmd.ent_rd) begin
            r_ent_q <= r_ents[i_ent_addr];
        end
    end

    assign o_ent_prefix = r_ent_q[EW-1 -: CW];
    assign o_ent_symbol = r_ent_q[CW +: 8];
    assign o_ent_link   = r_ent_q[CW-1:0];

endmodule

// ===== rtl/core/lzw_byte_stream_encoder.sv =====
// Flow: a byte is taken only in idle; its bucket head is read, then chain entries one at a time.
// A hit on an entry ends the byte; a miss adds a dictionary entry (or restarts the dictionary
// when full) and pushes the prefix code, whose output bytes drain as m_axis_tready allows.
// The first byte of a stream skips the lookup; end of stream pushes the final code and pad bits.
// Reset: synchronous active-low; dictionary restarts with only root codes, no clearing pass.
// End of stream returns the encoder to its reset state after the padded byte.
`include "assert_macros.svh"
module lzw_byte_stream_encoder #(
    parameter int DICT_ENTRIES = lzw_pkg::DICT_ENTRIES_DEF,
    parameter int BUCKETS      = lzw_pkg::BUCKETS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser    // [0] stream_done
);

    localparam int IW = $clog2(DICT_ENTRIES);
    localparam int CW = IW + 1;
    localparam int BW = $clog2(BUCKETS);
    localparam int PW = CW + 8;
    localparam int NW = $clog2(PW + 1);
    localparam int WW = $clog2(CW + 1);
    localparam logic [CW-1:0] NULL_CODE = '1;
    localparam logic [CW-1:0] ROOTS     = CW'(lzw_pkg::ROOT_COUNT);
    localparam logic [CW-1:0] LAST_ROOT = CW'(lzw_pkg::ROOT_COUNT - 1);
    localparam logic [CW-1:0] FULL_CODE = CW'(DICT_ENTRIES - 1);

    function automatic logic [BW-1:0] f_hash(input logic [CW-1:0] p, input logic [7:0] s);
        logic [31:0] v;
        v = 32'(p) ^ (32'(s) << lzw_pkg::SYM_SHIFT);
        return v[BW-1:0];
    endfunction

    lzw_pkg::t_state r_state, n_state;
    logic [CW-1:0] r_prefix, n_prefix;
    logic [CW-1:0] r_highest, n_highest;
    logic [WW-1:0] r_width, n_width;
    logic [PW-1:0] r_acc, n_acc;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_sym, n_sym;
    logic          r_last, n_last;
    logic [BW-1:0] r_bucket, n_bucket;
    logic [CW-1:0] r_head, n_head;
    logic [CW-1:0] r_addr, n_addr;
    logic          r_first, n_first;
    logic [CW-1:0] r_code, n_code;
    logic [WW-1:0] r_code_w, n_code_w;
    logic          r_need_code, n_need_code;
    logic          r_need_fin, n_need_fin;
    logic          r_need_pad, n_need_pad;

    lzw_pkg::t_dict_cmd dcmd;
    logic [BW-1:0] head_addr;
    logic [IW-1:0] ent_addr;
    logic [CW-1:0] wr_code;
    logic [CW-1:0] wr_link;
    logic [CW-1:0] d_head, d_prefix, d_link;
    logic [7:0]    d_symbol;
    logic          miss;
    logic          push;
    logic [CW-1:0] push_val;
    logic [WW-1:0] push_w;
    logic          finish;
    logic [NW-1:0] rem;

    lzw_dict #(.CW(CW), .IW(IW), .BW(BW)) u_dict (
        .i_clk       (i_clk),
        .i_cmd       (dcmd),
        .i_head_addr (head_addr),
        .i_ent_addr  (ent_addr),
        .i_wr_bucket (r_bucket),
        .i_wr_code   (wr_code),
        .i_wr_prefix (r_prefix),
        .i_wr_symbol (r_sym),
        .i_wr_link   (wr_link),
        .o_head      (d_head),
        .o_ent_prefix(d_prefix),
        .o_ent_symbol(d_symbol),
        .o_ent_link  (d_link)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzw_pkg::S_IDLE;
            r_prefix    <= NULL_CODE;
            r_highest   <= LAST_ROOT;
            r_width     <= WW'(lzw_pkg::START_WIDTH);
            r_cnt       <= '0;
            r_need_code <= 1'b0;
            r_need_fin  <= 1'b0;
            r_need_pad  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prefix    <= n_prefix;
            r_highest   <= n_highest;
            r_width     <= n_width;
            r_cnt       <= n_cnt;
            r_need_code <= n_need_code;
            r_need_fin  <= n_need_fin;
            r_need_pad  <= n_need_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_sym    <= n_sym;
        r_last   <= n_last;
        r_bucket <= n_bucket;
        r_head   <= n_head;
        r_addr   <= n_addr;
        r_first  <= n_first;
        r_code   <= n_code;
        r_code_w <= n_code_w;
    end

    assign rem           = r_cnt - NW'(8);
    assign m_axis_tvalid = (r_state == lzw_pkg::S_DRAIN) && (r_cnt >= NW'(8));
    assign m_axis_tdata  = 8'(r_acc >> rem);
    assign m_axis_tlast  = (rem < NW'(8)) && !r_need_code && !r_need_fin
                           && !(r_need_pad && (rem != '0));
    assign m_axis_tuser  = m_axis_tlast && r_last;
    assign s_axis_tready = (r_state == lzw_pkg::S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_prefix    = r_prefix;
        n_highest   = r_highest;
        n_width     = r_width;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_sym       = r_sym;
        n_last      = r_last;
        n_bucket    = r_bucket;
        n_head      = r_head;
        n_addr      = r_addr;
        n_first     = r_first;
        n_code      = r_code;
        n_code_w    = r_code_w;
        n_need_code = r_need_code;
        n_need_fin  = r_need_fin;
        n_need_pad  = r_need_pad;
        dcmd        = '0;
        head_addr   = f_hash(r_prefix, s_axis_tdata);
        ent_addr    = d_head[IW-1:0];
        wr_code     = r_highest + CW'(1);
        wr_link     = r_head;
        miss        = 1'b0;
        push        = 1'b0;
        push_val    = '0;
        push_w      = '0;
        finish      = 1'b0;

        case (r_state)
            lzw_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_sym      = s_axis_tdata;
                    n_last     = s_axis_tlast;
                    n_need_fin = s_axis_tlast;
                    if (r_prefix == NULL_CODE) begin
                        n_prefix = CW'(s_axis_tdata);
                        n_state  = lzw_pkg::S_PUSH;
                    end else begin
                        dcmd.head_rd = 1'b1;
                        n_bucket     = head_addr;
                        n_state      = lzw_pkg::S_HEAD;
                    end
                end
            end
            lzw_pkg::S_HEAD: begin
                if ((d_head >= ROOTS) && (d_head <= r_highest)) begin
                    dcmd.ent_rd = 1'b1;
                    ent_addr    = d_head[IW-1:0];
                    n_addr      = d_head;
                    n_head      = d_head;
                    n_first     = 1'b1;
                    n_state     = lzw_pkg::S_ENT;
                end else begin
                    wr_link = NULL_CODE;
                    miss    = 1'b1;
                end
            end
            lzw_pkg::S_ENT: begin
                if (r_first && (f_hash(d_prefix, d_symbol) != r_bucket)) begin
                    wr_link = NULL_CODE;
                    miss    = 1'b1;
                end else if ((d_prefix == r_prefix) && (d_symbol == r_sym)) begin
                    n_prefix = r_addr;
                    n_state  = lzw_pkg::S_PUSH;
                end else if ((d_link >= ROOTS) && (d_link <= r_highest)) begin
                    dcmd.ent_rd = 1'b1;
                    ent_addr    = d_link[IW-1:0];
                    n_addr      = d_link;
                    n_first     = 1'b0;
                end else begin
                    miss = 1'b1;
                end
            end
            lzw_pkg::S_PUSH: begin
                if (r_need_code) begin
                    push        = 1'b1;
                    push_val    = r_code;
                    push_w      = r_code_w;
                    n_need_code = 1'b0;
                end else if (r_need_fin) begin
                    push       = 1'b1;
                    push_val   = r_prefix;
                    push_w     = r_width;
                    n_need_fin = 1'b0;
                    n_need_pad = 1'b1;
                end else if (r_need_pad) begin
                    n_need_pad = 1'b0;
                    if (r_cnt != '0) begin
                        push   = 1'b1;
                        push_w = WW'(NW'(8) - r_cnt);
                    end else begin
                        finish = 1'b1;
                    end
                end else begin
                    finish = 1'b1;
                end
            end
            lzw_pkg::S_DRAIN: begin
                if (r_cnt >= NW'(8)) begin
                    if (m_axis_tready) begin
                        n_cnt = rem;
                    end
                end else begin
                    n_state = lzw_pkg::S_PUSH;
                end
            end
            default: begin
                n_state = lzw_pkg::S_IDLE;
            end
        endcase

        if (miss) begin
            n_code      = r_prefix;
            n_code_w    = r_width;
            n_need_code = 1'b1;
            if (({1'b0, r_highest} + (CW+1)'(1)) == ((CW+1)'(1) << r_width)) begin
                n_width = r_width + WW'(1);
            end
            if (r_highest == FULL_CODE) begin
                n_highest = LAST_ROOT;
                n_width   = WW'(lzw_pkg::START_WIDTH);
            end else begin
                n_highest = wr_code;
                dcmd.wr   = 1'b1;
            end
            n_prefix = CW'(r_sym);
            n_state  = lzw_pkg::S_PUSH;
        end

        if (push) begin
            n_acc   = (r_acc << push_w) | PW'(push_val);
            n_cnt   = r_cnt + NW'(push_w);
            n_state = lzw_pkg::S_DRAIN;
        end

        if (finish) begin
            n_state = lzw_pkg::S_IDLE;
            if (r_last) begin
                n_prefix  = NULL_CODE;
                n_highest = LAST_ROOT;
                n_width   = WW'(lzw_pkg::START_WIDTH);
                n_cnt     = '0;
            end
        end
    end

    `ASSERT_ALWAYS(a_highest_range, (r_highest >= LAST_ROOT) && (r_highest <= FULL_CODE))
    `ASSERT_IMPLY(a_idle_no_byte, s_axis_tready, r_cnt < NW'(8))
    `ASSERT_IMPLY(a_done_aligned, m_axis_tvalid && m_axis_tuser, r_cnt == NW'(8))

endmodule
